>>> hw/rtl/ptrs_pkg.sv
package ptrs_pkg;

    localparam int TICK_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int CNT_W    = 16;
    localparam int MASK_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int MODE_W   = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_RUN  = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

endpackage

>>> hw/rtl/ptrs_ram.sv
module ptrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ptrs_mod_unit.sv
module ptrs_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptrs_pkg::TICK_W-1:0]   dividend,
    input  logic [ptrs_pkg::PERIOD_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ptrs_pkg::PERIOD_W-1:0] remainder
);

    import ptrs_pkg::*;

    localparam int STEP_W = $clog2(TICK_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TICK_W-1:0]   dvd_reg, dvd_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W:0]   trial;

    // restoring division, one quotient bit a cycle, only the remainder is kept
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[TICK_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = PERIOD_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = PERIOD_W'(trial);
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("unit not busy after start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished run");

endmodule

>>> hw/rtl/periodic_task_release_scheduler.sv
// tick walks every slot: a used slot runs a 16-step remainder in the shared divider,
// a free slot is only checked; add runs a free-slot scan over up to SLOT_COUNT slots;
// running-mark modes and a zero-period add go straight to the response
// throughput: one item at a time; s_axis_tready is low while an item is worked on
// reset: tick counter, slot marks and output valid cleared, overrun_limit back to 255;
// period and count memories need no clearing, unused slots read as zero
module periodic_task_release_scheduler #(
    parameter int SLOT_COUNT = 8,
    parameter int TICK_WRAP  = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptrs_pkg::CNT_W-1:0]        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mode[1:0], slot[4:2], period_ticks[20:5]
    input  logic [ptrs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // release_mask[7:0], overrun_mask[15:8], add_ok[16], added_slot[19:17],
    // slot_overruns[35:20]
    output logic [ptrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import ptrs_pkg::*;

    localparam int IW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD   = 7'b0000010,
        ST_CHK  = 7'b0000100,
        ST_WAIT = 7'b0001000,
        ST_SCAN = 7'b0010000,
        ST_REQ  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] running_reg, running_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  cnt_ok_reg, cnt_ok_next;

    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [PERIOD_W-1:0]   per_reg, per_next;
    logic [MASK_W-1:0]     rel_reg, rel_next;
    logic [MASK_W-1:0]     ovr_reg, ovr_next;
    logic                  ok_reg, ok_next;
    logic [SLOT_W-1:0]     added_reg, added_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    mode_t                 in_mode;
    logic [SLOT_W-1:0]     in_slot;
    logic [PERIOD_W-1:0]   in_period;
    logic                  in_slot_ok;
    logic [IW-1:0]         in_slot_idx;
    logic [IW-1:0]         slot_idx;
    logic                  slot_ok;
    logic                  idx_last;
    logic                  idx_shown;

    logic                  per_we, per_re;
    logic [PERIOD_W-1:0]   per_rdata;
    logic                  cnt_we, cnt_re;
    logic [IW-1:0]         cnt_raddr;
    logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;

    logic                  mod_start, mod_busy, mod_done;
    logic [PERIOD_W-1:0]   mod_rem;

    logic                  claim;
    logic                  hit;
    logic                  bump;

    assign in_mode     = mode_t'(s_axis_tdata[MODE_W-1:0]);
    assign in_slot     = s_axis_tdata[MODE_W +: SLOT_W];
    assign in_period   = s_axis_tdata[MODE_W+SLOT_W +: PERIOD_W];
    assign in_slot_ok  = 32'(in_slot) < SLOT_COUNT;
    assign in_slot_idx = IW'(in_slot);
    assign slot_idx    = IW'(slot_reg);
    assign slot_ok     = 32'(slot_reg) < SLOT_COUNT;
    assign idx_last    = idx_reg == IW'(SLOT_COUNT - 1);
    assign idx_shown   = 32'(idx_reg) < MASK_W;

    assign claim = state_reg == ST_SCAN && !used_reg[idx_reg];
    assign hit   = state_reg == ST_WAIT && mod_done && mod_rem == '0;
    assign bump  = hit && running_reg[idx_reg] && cnt_rdata < lim_reg;

    assign per_we    = claim;
    assign per_re    = state_reg == ST_RD;
    assign cnt_we    = claim || bump;
    assign cnt_wdata = claim ? '0 : cnt_rdata + CNT_W'(1);
    assign cnt_re    = state_reg == ST_RD || (state_reg == ST_REQ && slot_ok);
    assign cnt_raddr = state_reg == ST_REQ ? slot_idx : idx_reg;

    assign mod_start = state_reg == ST_CHK && used_reg[idx_reg] && per_rdata != '0;

    ptrs_ram #(.WIDTH(PERIOD_W), .DEPTH(SLOT_COUNT)) u_per_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (idx_reg),
        .wdata (per_reg),
        .re    (per_re),
        .raddr (idx_reg),
        .rdata (per_rdata)
    );

    ptrs_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (idx_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    ptrs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (tick_reg),
        .divisor   (per_rdata),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        used_next      = used_reg;
        running_next   = running_reg;
        lim_next       = cfg_we ? cfg_wdata : lim_reg;
        out_valid_next = out_valid_reg;
        cnt_ok_next    = cnt_ok_reg;
        slot_next      = slot_reg;
        per_next       = per_reg;
        rel_next       = rel_reg;
        ovr_next       = ovr_reg;
        ok_next        = ok_reg;
        added_next     = added_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    slot_next  = in_slot;
                    per_next   = in_period;
                    rel_next   = '0;
                    ovr_next   = '0;
                    ok_next    = 1'b0;
                    added_next = '0;
                    idx_next   = '0;
                    case (in_mode)
                        MODE_TICK:
                        begin
                            if (tick_reg == TICK_W'(TICK_WRAP - 1))
                            begin
                                tick_next = '0;
                            end
                            else
                            begin
                                tick_next = tick_reg + TICK_W'(1);
                            end
                            state_next = ST_RD;
                        end
                        MODE_ADD:
                        begin
                            tick_next  = '0;
                            state_next = in_period == '0 ? ST_REQ : ST_SCAN;
                        end
                        MODE_RUN, MODE_STOP:
                        begin
                            if (in_slot_ok)
                            begin
                                running_next[in_slot_idx] = in_mode == MODE_RUN;
                            end
                            state_next = ST_REQ;
                        end
                        default:
                        begin
                            state_next = ST_REQ;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (mod_start)
                begin
                    state_next = ST_WAIT;
                end
                else if (idx_last)
                begin
                    state_next = ST_REQ;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_RD;
                end
            end
            ST_WAIT:
            begin
                if (mod_done)
                begin
                    if (hit && idx_shown)
                    begin
                        rel_next[3'(idx_reg)] = 1'b1;
                        ovr_next[3'(idx_reg)] = running_reg[idx_reg];
                    end
                    if (idx_last)
                    begin
                        state_next = ST_REQ;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (claim)
                begin
                    used_next[idx_reg]    = 1'b1;
                    running_next[idx_reg] = 1'b0;
                    ok_next               = 1'b1;
                    added_next            = 3'(idx_reg);
                    state_next            = ST_REQ;
                end
                else if (idx_last)
                begin
                    state_next = ST_REQ;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_REQ:
            begin
                // count memory read for the addressed slot is issued here
                cnt_ok_next = slot_ok && used_reg[slot_idx];
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, cnt_ok_reg ? cnt_rdata : CNT_W'(0),
                                      added_reg, ok_reg, ovr_reg, rel_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            tick_reg      <= '0;
            used_reg      <= '0;
            running_reg   <= '0;
            lim_reg       <= CNT_W'(255);
            out_valid_reg <= 1'b0;
            cnt_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            running_reg   <= running_next;
            lim_reg       <= lim_next;
            out_valid_reg <= out_valid_next;
            cnt_ok_reg    <= cnt_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        per_reg      <= per_next;
        rel_reg      <= rel_next;
        ovr_reg      <= ovr_next;
        ok_reg       <= ok_next;
        added_reg    <= added_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_wait_has_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && !mod_done) |-> mod_busy)
        else $error("waiting on an idle divider");

    a_ovr_within_rel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] & ~m_axis_tdata[7:0]) == '0)
        else $error("overrun flagged on a slot not released");

    a_add_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> m_axis_tdata[15:0] == '0)
        else $error("release reported on an add");

    a_claim_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        claim |=> used_reg[$past(idx_reg)] && !running_reg[$past(idx_reg)])
        else $error("claimed slot not marked used");

endmodule
